// ----- hdl/lts_pkg.sv -----
// Shared types, constants and byte classification for the Lisp token scanner.
package lts_pkg;

   localparam longint unsigned DEFAULT_MAX_TEXT = 64'd65535;
   localparam int unsigned DEFAULT_QUEUE_DEPTH = 4;

   localparam logic [1:0] KIND_TOKEN = 2'd0;
   localparam logic [1:0] KIND_END   = 2'd1;
   localparam logic [1:0] KIND_ERROR = 2'd2;

   localparam logic [7:0] CH_NUL    = 8'h00;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_COMMA  = 8'h2C;
   localparam logic [7:0] CH_DQUOTE = 8'h22;
   localparam logic [7:0] CH_SQUOTE = 8'h27;
   localparam logic [7:0] CH_SEMI   = 8'h3B;
   localparam logic [7:0] CH_LBRACK = 8'h5B;
   localparam logic [7:0] CH_RBRACK = 8'h5D;
   localparam logic [7:0] CH_LBRACE = 8'h7B;
   localparam logic [7:0] CH_RBRACE = 8'h7D;
   localparam logic [7:0] CH_LPAREN = 8'h28;
   localparam logic [7:0] CH_RPAREN = 8'h29;
   localparam logic [7:0] CH_TILDE  = 8'h7E;
   localparam logic [7:0] CH_CARET  = 8'h5E;
   localparam logic [7:0] CH_AT     = 8'h40;
   localparam logic [7:0] CH_BSLASH = 8'h5C;

   typedef enum logic [2:0] {
      MODE_IDLE    = 3'd0,
      MODE_SYMBOL  = 3'd1,
      MODE_STRING  = 3'd2,
      MODE_TILDE   = 3'd3,
      MODE_SWALLOW = 3'd4
   } mode_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [15:0] offset;
      logic [15:0] length;
   } result_type;

   // All results caused by one accepted byte.
   typedef struct packed {
      logic       two;
      result_type first;
      result_type second;
   } event_type;

   function automatic logic is_separator(input logic [7:0] b);
      return (b != CH_NUL && b <= CH_SPACE) || b == CH_COMMA;
   endfunction

   function automatic logic is_bracket(input logic [7:0] b);
      return b == CH_LBRACK || b == CH_RBRACK || b == CH_LBRACE ||
             b == CH_RBRACE || b == CH_LPAREN || b == CH_RPAREN ||
             b == CH_SQUOTE;
   endfunction

   function automatic logic ends_symbol(input logic [7:0] b);
      return b == CH_NUL || is_separator(b) || is_bracket(b) ||
             b == CH_DQUOTE || b == CH_SEMI;
   endfunction

endpackage

// ----- hdl/lisp_token_scanner.sv -----
// Top level of the Lisp token scanner: front end, result queue and back end.
//
//   channel  direction  handshake          payload
//   req      in         req_push/req_full  req_text_byte
//   rsp      out        rsp_pop/rsp_empty  rsp_result_kind, rsp_token_offset,
//                                          rsp_token_length, rsp_last_of_run
//
// One byte is accepted per cycle while the result queue has room; its result
// items are written to the queue in the same cycle.
// A byte that closes a token and is a one-byte token or ';' gives two result
// items, one per pop; one item leaves per cycle while popped and not empty.
// Reset is synchronous and clears the scan state and the queue.
// The input stalls only when the queue of QUEUE_DEPTH result item sets is full.
module lisp_token_scanner import lts_pkg::*; #(
   parameter longint unsigned MAX_TEXT    = DEFAULT_MAX_TEXT,
   parameter int unsigned     QUEUE_DEPTH = DEFAULT_QUEUE_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic [7:0]  req_text_byte,
   input  logic        rsp_pop,
   output logic        rsp_empty,
   output logic [1:0]  rsp_result_kind,
   output logic [15:0] rsp_token_offset,
   output logic [15:0] rsp_token_length,
   output logic        rsp_last_of_run
);

   logic      accept;
   logic      has_result;
   event_type ev;
   event_type head;
   logic      head_empty;
   logic      deq;

   assign accept = req_push && !req_full;

   lts_front #(.MAX_TEXT(MAX_TEXT)) u_front (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .text_byte  (req_text_byte),
      .has_result (has_result),
      .ev         (ev)
   );

   lts_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
      .clock    (clock),
      .reset    (reset),
      .enq      (accept && has_result),
      .enq_data (ev),
      .deq      (deq),
      .head     (head),
      .full     (req_full),
      .empty    (head_empty)
   );

   lts_back u_back (
      .clock            (clock),
      .reset            (reset),
      .head             (head),
      .head_empty       (head_empty),
      .deq              (deq),
      .rsp_pop          (rsp_pop),
      .rsp_empty        (rsp_empty),
      .rsp_result_kind  (rsp_result_kind),
      .rsp_token_offset (rsp_token_offset),
      .rsp_token_length (rsp_token_length),
      .rsp_last_of_run  (rsp_last_of_run)
   );

   a_reset_empties: assert property (@(posedge clock) reset |=> rsp_empty)
      else $error("result queue not empty after reset");

   a_full_not_empty: assert property (@(posedge clock) disable iff (reset)
      req_full |-> !rsp_empty)
      else $error("input stalled while no result item waits");

   a_kind_valid: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> rsp_result_kind != 2'd3)
      else $error("undefined result kind on output");

   a_pair_follows: assert property (@(posedge clock) disable iff (reset)
      (rsp_pop && !rsp_empty && !rsp_last_of_run) |=> (!rsp_empty && rsp_last_of_run))
      else $error("second result item of a byte missing");

endmodule

// ----- hdl/lts_front.sv -----
// Front end: classifies each byte, tracks scan state and builds its result item set.
module lts_front import lts_pkg::*; #(
   parameter longint unsigned MAX_TEXT = DEFAULT_MAX_TEXT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       accept,
   input  logic [7:0] text_byte,
   output logic       has_result,
   output event_type  ev
);

   localparam int unsigned POS_W = $clog2(MAX_TEXT + 64'd1);
   localparam logic [POS_W-1:0] MAX_POS = POS_W'(MAX_TEXT);

   logic [POS_W-1:0] pos_ff, pos_in;
   logic [15:0]      start_ff, start_in;
   mode_type         mode_ff, mode_in;
   logic             esc_ff, esc_in;

   logic [15:0] pos16;
   logic        go_idle;
   logic        idle_hit;
   result_type  idle_res;

   assign pos16 = 16'(pos_ff);

   always_comb begin
      mode_in    = mode_ff;
      start_in   = start_ff;
      esc_in     = esc_ff;
      pos_in     = (pos_ff < MAX_POS) ? pos_ff + 1'b1 : MAX_POS;
      ev         = '0;
      has_result = 1'b0;
      go_idle    = 1'b0;
      idle_hit   = 1'b0;
      idle_res   = '0;

      case (mode_ff)
         MODE_SYMBOL: begin
            if (ends_symbol(text_byte)) begin
               ev.first   = '{kind: KIND_TOKEN, offset: start_ff, length: pos16 - start_ff};
               has_result = 1'b1;
               mode_in    = MODE_IDLE;
               go_idle    = 1'b1;
            end
         end
         MODE_STRING: begin
            if (text_byte == CH_NUL) begin
               ev.first   = '{kind: KIND_ERROR, offset: start_ff, length: 16'd0};
               has_result = 1'b1;
               pos_in     = '0;
               start_in   = '0;
               mode_in    = MODE_IDLE;
               esc_in     = 1'b0;
            end else if (!esc_ff && text_byte == CH_DQUOTE) begin
               ev.first   = '{kind: KIND_TOKEN, offset: start_ff,
                              length: pos16 - start_ff + 16'd1};
               has_result = 1'b1;
               mode_in    = MODE_IDLE;
               esc_in     = 1'b0;
            end else begin
               esc_in = !esc_ff && text_byte == CH_BSLASH;
            end
         end
         MODE_TILDE: begin
            has_result = 1'b1;
            mode_in    = MODE_IDLE;
            if (text_byte == CH_AT) begin
               ev.first = '{kind: KIND_TOKEN, offset: start_ff, length: 16'd2};
            end else begin
               ev.first = '{kind: KIND_TOKEN, offset: start_ff, length: 16'd1};
               go_idle  = 1'b1;
            end
         end
         MODE_SWALLOW: begin
            if (text_byte == CH_NUL) begin
               pos_in   = '0;
               start_in = '0;
               mode_in  = MODE_IDLE;
               esc_in   = 1'b0;
            end
         end
         default: begin
            go_idle = 1'b1;
         end
      endcase

      if (go_idle) begin
         if (text_byte == CH_NUL) begin
            pos_in   = '0;
            start_in = '0;
            mode_in  = MODE_IDLE;
            esc_in   = 1'b0;
         end else if (is_separator(text_byte)) begin
            mode_in = MODE_IDLE;
         end else if (text_byte == CH_DQUOTE) begin
            mode_in  = MODE_STRING;
            start_in = pos16;
            esc_in   = 1'b0;
         end else if (text_byte == CH_SEMI) begin
            idle_hit = 1'b1;
            idle_res = '{kind: KIND_END, offset: pos16, length: 16'd0};
            mode_in  = MODE_SWALLOW;
         end else if (is_bracket(text_byte) || text_byte == CH_CARET ||
                      text_byte == CH_AT) begin
            idle_hit = 1'b1;
            idle_res = '{kind: KIND_TOKEN, offset: pos16, length: 16'd1};
            mode_in  = MODE_IDLE;
         end else if (text_byte == CH_TILDE) begin
            mode_in  = MODE_TILDE;
            start_in = pos16;
         end else begin
            mode_in  = MODE_SYMBOL;
            start_in = pos16;
         end

         if (idle_hit) begin
            if (has_result) begin
               ev.second = idle_res;
               ev.two    = 1'b1;
            end else begin
               ev.first   = idle_res;
               has_result = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= '0;
         start_ff <= '0;
         mode_ff  <= MODE_IDLE;
         esc_ff   <= 1'b0;
      end else if (accept) begin
         pos_ff   <= pos_in;
         start_ff <= start_in;
         mode_ff  <= mode_in;
         esc_ff   <= esc_in;
      end
   end

endmodule

// ----- hdl/lts_queue.sv -----
// Short register queue that holds result item sets between front and back.
module lts_queue import lts_pkg::*; #(
   parameter int unsigned DEPTH = DEFAULT_QUEUE_DEPTH
) (
   input  logic      clock,
   input  logic      reset,
   input  logic      enq,
   input  event_type enq_data,
   input  logic      deq,
   output event_type head,
   output logic      full,
   output logic      empty
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   event_type        slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_enq, do_deq;

   assign full   = count_ff == FULL_CNT;
   assign empty  = count_ff == '0;
   assign head   = slot_ff[rd_ptr_ff];
   assign do_enq = enq && !full;
   assign do_deq = deq && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_enq) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_deq) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_enq && !do_deq) begin
         count_in = count_ff + 1'b1;
      end else if (do_deq && !do_enq) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_enq) begin
         slot_ff[wr_ptr_ff] <= enq_data;
      end
   end

endmodule

// ----- hdl/lts_back.sv -----
// Back end: hands out the queued result item sets one result item at a time.
module lts_back import lts_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  event_type   head,
   input  logic        head_empty,
   output logic        deq,
   input  logic        rsp_pop,
   output logic        rsp_empty,
   output logic [1:0]  rsp_result_kind,
   output logic [15:0] rsp_token_offset,
   output logic [15:0] rsp_token_length,
   output logic        rsp_last_of_run
);

   logic       second_ff, second_in;
   logic       take;
   result_type shown;

   assign rsp_empty = head_empty;
   assign take      = rsp_pop && !head_empty;
   assign deq       = take && (second_ff || !head.two);
   assign shown     = second_ff ? head.second : head.first;

   assign rsp_result_kind  = shown.kind;
   assign rsp_token_offset = shown.offset;
   assign rsp_token_length = shown.length;
   assign rsp_last_of_run  = second_ff || !head.two;

   always_comb begin
      second_in = second_ff;
      if (take) begin
         second_in = !second_ff && head.two;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         second_ff <= 1'b0;
      end else begin
         second_ff <= second_in;
      end
   end

endmodule

// ----- tb/sv/tb_lisp_token_scanner.sv -----
// Self-checking testbench for the Lisp token scanner, driven through its queue handshakes.
module tb_lisp_token_scanner import lts_pkg::*;;

   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [1:0]  kind;
      logic [15:0] offset;
      logic [15:0] length;
      logic        last;
   } scan_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_push = 1'b0;
   logic        req_full;
   logic [7:0]  req_text_byte = 8'h00;
   logic        rsp_pop = 1'b0;
   logic        rsp_empty;
   logic [1:0]  rsp_result_kind;
   logic [15:0] rsp_token_offset;
   logic [15:0] rsp_token_length;
   logic        rsp_last_of_run;

   scan_result_type expected_tokens[$];
   scan_result_type byte_results[$];
   logic [15:0]     text_pos;
   logic [15:0]     tok_start;
   mode_type        scan_state;
   logic            esc_seen;

   int send_gap_pct = 0;
   int pop_gap_pct = 0;
   int bytes_sent = 0;
   int errors = 0;

   logic [7:0] single_tokens[9] = '{CH_LPAREN, CH_RPAREN, CH_LBRACK, CH_RBRACK, CH_LBRACE,
                                    CH_RBRACE, CH_SQUOTE, CH_CARET, CH_AT};

   lisp_token_scanner u_top (
      .clock            (clock),
      .reset            (reset),
      .req_push         (req_push),
      .req_full         (req_full),
      .req_text_byte    (req_text_byte),
      .rsp_pop          (rsp_pop),
      .rsp_empty        (rsp_empty),
      .rsp_result_kind  (rsp_result_kind),
      .rsp_token_offset (rsp_token_offset),
      .rsp_token_length (rsp_token_length),
      .rsp_last_of_run  (rsp_last_of_run)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("Verification failed");
      $finish;
   end

   function automatic logic is_gap(input logic [7:0] b);
      return (b >= 8'h01 && b <= CH_SPACE) || b == CH_COMMA;
   endfunction

   function automatic logic stops_symbol(input logic [7:0] b);
      return b == CH_NUL || is_gap(b) || b == CH_LBRACK || b == CH_RBRACK ||
             b == CH_LBRACE || b == CH_RBRACE || b == CH_LPAREN || b == CH_RPAREN ||
             b == CH_SQUOTE || b == CH_DQUOTE || b == CH_SEMI;
   endfunction

   task automatic restart_text();
      text_pos = 16'd0;
      tok_start = 16'd0;
      scan_state = MODE_IDLE;
      esc_seen = 1'b0;
   endtask

   task automatic add_result(input logic [1:0] kind, input logic [15:0] offset,
                             input logic [15:0] length);
      byte_results.push_back('{kind, offset, length, 1'b0});
   endtask

   task automatic scan_from_idle(input logic [7:0] b, input logic [15:0] pos);
      if (b == CH_NUL) begin
         restart_text();
      end else if (is_gap(b)) begin
      end else if (b == CH_DQUOTE) begin
         scan_state = MODE_STRING;
         tok_start = pos;
         esc_seen = 1'b0;
      end else if (b == CH_SEMI) begin
         add_result(KIND_END, pos, 16'd0);
         scan_state = MODE_SWALLOW;
      end else if (b == CH_TILDE) begin
         scan_state = MODE_TILDE;
         tok_start = pos;
      end else if (b inside {CH_LBRACK, CH_RBRACK, CH_LBRACE, CH_RBRACE, CH_LPAREN,
                             CH_RPAREN, CH_SQUOTE, CH_CARET, CH_AT}) begin
         add_result(KIND_TOKEN, pos, 16'd1);
         scan_state = MODE_IDLE;
      end else begin
         scan_state = MODE_SYMBOL;
         tok_start = pos;
      end
   endtask

   task automatic predict_tokens(input logic [7:0] b);
      logic [15:0] pos;
      pos = text_pos;
      byte_results.delete();
      if (text_pos < DEFAULT_MAX_TEXT) text_pos = text_pos + 16'd1;
      case (scan_state)
         MODE_SYMBOL: begin
            if (stops_symbol(b)) begin
               add_result(KIND_TOKEN, tok_start, pos - tok_start);
               scan_state = MODE_IDLE;
               scan_from_idle(b, pos);
            end
         end
         MODE_STRING: begin
            if (b == CH_NUL) begin
               add_result(KIND_ERROR, tok_start, 16'd0);
               restart_text();
            end else if (!esc_seen && b == CH_DQUOTE) begin
               add_result(KIND_TOKEN, tok_start, pos - tok_start + 16'd1);
               scan_state = MODE_IDLE;
               esc_seen = 1'b0;
            end else begin
               esc_seen = !esc_seen && b == CH_BSLASH;
            end
         end
         MODE_TILDE: begin
            if (b == CH_AT) begin
               add_result(KIND_TOKEN, tok_start, 16'd2);
               scan_state = MODE_IDLE;
            end else begin
               add_result(KIND_TOKEN, tok_start, 16'd1);
               scan_state = MODE_IDLE;
               scan_from_idle(b, pos);
            end
         end
         MODE_SWALLOW: begin
            if (b == CH_NUL) restart_text();
         end
         default: scan_from_idle(b, pos);
      endcase
      if (byte_results.size() > 0) byte_results[$].last = 1'b1;
      foreach (byte_results[k]) expected_tokens.push_back(byte_results[k]);
   endtask

   task automatic push_text_byte(input logic [7:0] b);
      while ($urandom_range(99) < send_gap_pct) begin
         req_push <= 1'b0;
         @(posedge clock);
      end
      req_push <= 1'b1;
      req_text_byte <= b;
      do @(posedge clock); while (req_full);
      predict_tokens(b);
      bytes_sent++;
   endtask

   task automatic send_text(input string s);
      for (int k = 0; k < s.len(); k++) push_text_byte(s[k]);
   endtask

   task automatic wait_for_drain();
      req_push <= 1'b0;
      @(posedge clock);
      while (expected_tokens.size() != 0) @(posedge clock);
   endtask

   function automatic logic [7:0] pick_symbol_byte(input bit first);
      logic [7:0] b;
      b = 8'($urandom_range(33, 255));
      while (stops_symbol(b) || (first && (b == CH_TILDE || b == CH_CARET || b == CH_AT)))
         b = 8'($urandom_range(33, 255));
      return b;
   endfunction

   function automatic logic [7:0] pick_gap_byte();
      case ($urandom_range(3))
         0, 1: return CH_SPACE;
         2: return CH_COMMA;
         default: return 8'($urandom_range(1, 32));
      endcase
   endfunction

   function automatic logic [7:0] pick_string_byte();
      case ($urandom_range(9))
         0, 1: return CH_BSLASH;
         2: return CH_DQUOTE;
         default: return 8'($urandom_range(1, 255));
      endcase
   endfunction

   task automatic send_random_text();
      int pick;
      if ($urandom_range(3) == 0) begin
         repeat ($urandom_range(1, 20)) push_text_byte(8'($urandom_range(255)));
         return;
      end
      repeat ($urandom_range(1, 12)) begin
         pick = $urandom_range(99);
         if (pick < 30) begin
            push_text_byte(pick_symbol_byte(1'b1));
            repeat ($urandom_range(0, 5)) push_text_byte(pick_symbol_byte(1'b0));
         end else if (pick < 45) begin
            push_text_byte(CH_DQUOTE);
            repeat ($urandom_range(0, 6)) push_text_byte(pick_string_byte());
            if ($urandom_range(19) == 0) begin
               push_text_byte(CH_NUL);
               return;
            end
            push_text_byte(CH_DQUOTE);
         end else if (pick < 75) begin
            push_text_byte(single_tokens[$urandom_range(8)]);
         end else if (pick < 85) begin
            push_text_byte(CH_TILDE);
            if ($urandom_range(1)) push_text_byte(CH_AT);
         end else if (pick < 90) begin
            push_text_byte(CH_SEMI);
            repeat ($urandom_range(0, 5)) push_text_byte(8'($urandom_range(1, 255)));
            push_text_byte(CH_NUL);
            return;
         end else begin
            repeat ($urandom_range(1, 3)) push_text_byte(pick_gap_byte());
         end
         if ($urandom_range(9) < 6) push_text_byte(pick_gap_byte());
      end
      push_text_byte(CH_NUL);
   endtask

   task automatic check_scan_result();
      scan_result_type exp;
      if (expected_tokens.size() == 0) begin
         $error("unexpected result: kind %0d offset %0d length %0d", rsp_result_kind,
                rsp_token_offset, rsp_token_length);
         errors++;
      end else begin
         exp = expected_tokens.pop_front();
         if (rsp_result_kind !== exp.kind) begin
            $error("result_kind: expected %0d, actual %0d", exp.kind, rsp_result_kind);
            errors++;
         end
         if (rsp_token_offset !== exp.offset) begin
            $error("token_offset: expected %0d, actual %0d", exp.offset, rsp_token_offset);
            errors++;
         end
         if (rsp_token_length !== exp.length) begin
            $error("token_length: expected %0d, actual %0d", exp.length, rsp_token_length);
            errors++;
         end
         if (rsp_last_of_run !== exp.last) begin
            $error("last_of_run: expected %0d, actual %0d", exp.last, rsp_last_of_run);
            errors++;
         end
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_pop && !rsp_empty) check_scan_result();
      rsp_pop <= ($urandom_range(99) >= pop_gap_pct);
   end

   task automatic test_directed_text();
      send_text("()[]{}'^@~@~\377(,\001\"\\\"\" \"a");
      push_text_byte(CH_NUL);
      send_text("~");
      push_text_byte(CH_NUL);
      send_text(";z");
      push_text_byte(CH_NUL);
   endtask

   task automatic test_random_texts(input int n_items);
      int start;
      start = bytes_sent;
      while (bytes_sent - start < n_items) send_random_text();
   endtask

   task automatic test_long_text();
      for (int k = 0; k < 250; k++)
         push_text_byte(($urandom_range(31) == 0) ? pick_symbol_byte(1'b1) : CH_SPACE);
      repeat (40) push_text_byte(pick_symbol_byte(1'b0));
      send_text("()\"s\"~@;zz");
      push_text_byte(CH_NUL);
   endtask

   initial begin
      int guard;
      restart_text();
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      test_directed_text();
      wait_for_drain();
      send_gap_pct = 30;
      pop_gap_pct = 45;
      test_random_texts(400);
      wait_for_drain();
      send_gap_pct = 45;
      pop_gap_pct = 30;
      test_random_texts(400);
      wait_for_drain();
      send_gap_pct = 0;
      pop_gap_pct = 0;
      test_random_texts(400);
      test_long_text();
      req_push <= 1'b0;
      guard = 0;
      while (expected_tokens.size() != 0 && guard < 100000) begin
         @(posedge clock);
         guard++;
      end
      repeat (20) @(posedge clock);
      if (expected_tokens.size() != 0) begin
         $error("%0d expected results never arrived", expected_tokens.size());
         errors++;
      end
      if (errors == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
